// ----- sv/srq_pkg.sv -----
// Package for the sorted ready queue.
// Holds default sizes, command and status codes and the cell control struct.
// No dependencies.
package srq_pkg;

  localparam int unsigned DepthDef    = 64;
  localparam int unsigned KeyWidthDef = 16;
  localparam int unsigned IdWidthDef  = 8;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef enum logic {
    ModeFifo   = 1'b0,
    ModeSorted = 1'b1
  } mode_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic sorted;
  } srq_ctrl_t;

endpackage

// ----- sv/srq_cell.sv -----
// One slot of the sorted ready queue: valid bit, key and id.
// Shifts toward the tail on insert, toward the head on pop.
// Depends on srq_pkg.
module srq_cell import srq_pkg::*; #(
  parameter int unsigned KeyWidth = KeyWidthDef,
  parameter int unsigned IdWidth  = IdWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srq_ctrl_t           ctrl_i,
  input  logic [KeyWidth-1:0] new_key_i,
  input  logic [IdWidth-1:0]  new_id_i,
  input  logic                found_i,
  input  logic                left_valid_i,
  input  logic [KeyWidth-1:0] left_key_i,
  input  logic [IdWidth-1:0]  left_id_i,
  input  logic                right_valid_i,
  input  logic [KeyWidth-1:0] right_key_i,
  input  logic [IdWidth-1:0]  right_id_i,
  output logic                found_o,
  output logic                valid_o,
  output logic [KeyWidth-1:0] key_o,
  output logic [IdWidth-1:0]  id_o
);

  logic                valid_q, valid_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic [IdWidth-1:0]  id_q, id_d;
  logic                ranks_before;

  assign ranks_before = !valid_q ||
      (ctrl_i.sorted && ((new_key_i < key_q) ||
                         ((new_key_i == key_q) && (new_id_i < id_q))));
  assign found_o = found_i || ranks_before;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    id_d    = id_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      id_d    = right_id_i;
    end else if (ctrl_i.push) begin
      if (found_i) begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        id_d    = left_id_i;
      end else if (ranks_before) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        id_d    = new_id_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign id_o    = id_q;

endmodule

// ----- sv/sorted_ready_queue.sv -----
// Sorted ready queue: a row of DEPTH cells, head at cell 0.
// A result appears in the cycle after its request is accepted.
// Throughput: one push or pop per cycle while req_stall_o is low; the insert
// position comes from a prefix chain over all cells in the same cycle.
// Reset clears all valid bits, the count, the mode and the result register.
module sorted_ready_queue import srq_pkg::*; #(
  parameter int unsigned DEPTH     = DepthDef,
  parameter int unsigned KEY_WIDTH = KeyWidthDef,
  parameter int unsigned ID_WIDTH  = IdWidthDef,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  logic                 cmd_i,
  input  logic [ID_WIDTH-1:0]  in_id_i,
  input  logic [KEY_WIDTH-1:0] in_key_i,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output logic                 out_valid_o,
  output logic [ID_WIDTH-1:0]  out_id_o,
  output logic [KEY_WIDTH-1:0] out_key_o,
  output logic [1:0]           status_o,
  output logic [CntW-1:0]      occupancy_o
);

  logic                 mode_q;
  logic [CntW-1:0]      count_q, count_d;
  logic                 res_valid_q;
  logic                 out_valid_q, out_valid_d;
  logic [ID_WIDTH-1:0]  out_id_q, out_id_d;
  logic [KEY_WIDTH-1:0] out_key_q, out_key_d;
  status_e              status_q, status_d;
  logic                 accept;
  logic                 full, empty;
  srq_ctrl_t            ctrl;

  logic                 cell_valid [DEPTH];
  logic [KEY_WIDTH-1:0] cell_key   [DEPTH];
  logic [ID_WIDTH-1:0]  cell_id    [DEPTH];
  logic                 found      [DEPTH+1];

  assign cfg_ready_o = 1'b1;
  assign req_stall_o = res_valid_q && res_stall_i;
  assign accept      = req_valid_i && !req_stall_o;
  assign full        = (count_q == CntW'(DEPTH));
  assign empty       = (count_q == '0);

  assign ctrl.push   = accept && (cmd_e'(cmd_i) == CmdPush) && !full;
  assign ctrl.pop    = accept && (cmd_e'(cmd_i) == CmdPop) && !empty;
  assign ctrl.sorted = (mode_e'(mode_q) == ModeSorted);

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_valid, right_valid;
    logic [KEY_WIDTH-1:0] left_key, right_key;
    logic [ID_WIDTH-1:0]  left_id, right_id;

    if (i == 0) begin : g_head
      assign left_valid = 1'b0;
      assign left_key   = '0;
      assign left_id    = '0;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_key   = cell_key[i-1];
      assign left_id    = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_key   = '0;
      assign right_id    = '0;
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_key   = cell_key[i+1];
      assign right_id    = cell_id[i+1];
    end

    srq_cell #(
      .KeyWidth(KEY_WIDTH),
      .IdWidth (ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (in_key_i),
      .new_id_i     (in_id_i),
      .found_i      (found[i]),
      .left_valid_i (left_valid),
      .left_key_i   (left_key),
      .left_id_i    (left_id),
      .right_valid_i(right_valid),
      .right_key_i  (right_key),
      .right_id_i   (right_id),
      .found_o      (found[i+1]),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .id_o         (cell_id[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_id_d    = '0;
    out_key_d   = '0;
    status_d    = StatusOk;
    if (cmd_e'(cmd_i) == CmdPush) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StatusEmpty;
      end else begin
        out_valid_d = 1'b1;
        out_id_d    = cell_id[0];
        out_key_d   = cell_key[0];
        count_d     = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_key_q   <= '0;
      status_q    <= StatusOk;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
        count_q     <= count_d;
        out_valid_q <= out_valid_d;
        out_id_q    <= out_id_d;
        out_key_q   <= out_key_d;
        status_q    <= status_d;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_key_o   = out_key_q;
  assign status_o    = status_q;
  assign occupancy_o = count_q;

endmodule

// ----- dv/tb_sorted_ready_queue.sv -----
// Testbench for sorted_ready_queue: directed and random push/pop requests in FIFO
// and sorted modes, checked against a queue model held in a small scoreboard.
// Depends on srq_pkg and the sorted_ready_queue RTL.

typedef struct packed {
  logic                                   valid;
  logic [srq_pkg::IdWidthDef-1:0]         id;
  logic [srq_pkg::KeyWidthDef-1:0]        key;
  logic [1:0]                             status;
  logic [$clog2(srq_pkg::DepthDef+1)-1:0] occ;
} srq_result_t;

class ready_queue_tracker;
  localparam int OccW = $clog2(srq_pkg::DepthDef + 1);

  logic [srq_pkg::KeyWidthDef-1:0] keys[$];
  logic [srq_pkg::IdWidthDef-1:0]  ids[$];
  srq_pkg::mode_e                  mode = srq_pkg::ModeFifo;
  srq_result_t                     due_results[$];
  int                              errors = 0;
  int                              requests = 0;
  int                              served = 0;
  int                              drops = 0;
  int                              empty_pops = 0;

  function void note_request(srq_pkg::cmd_e cmd, logic [srq_pkg::IdWidthDef-1:0] id,
                             logic [srq_pkg::KeyWidthDef-1:0] key);
    srq_result_t r;
    int          pos;
    r = '0;
    r.status = srq_pkg::StatusOk;
    requests++;
    if (cmd == srq_pkg::CmdPush) begin
      if (keys.size() >= srq_pkg::DepthDef) begin
        r.status = srq_pkg::StatusFull;
        drops++;
      end else begin
        pos = keys.size();
        if (mode == srq_pkg::ModeSorted) begin
          for (int i = 0; i < keys.size(); i++) begin
            if (key < keys[i] || (key == keys[i] && id < ids[i])) begin
              pos = i;
              break;
            end
          end
        end
        keys.insert(pos, key);
        ids.insert(pos, id);
      end
    end else if (keys.size() == 0) begin
      r.status = srq_pkg::StatusEmpty;
      empty_pops++;
    end else begin
      r.valid = 1'b1;
      r.id    = ids.pop_front();
      r.key   = keys.pop_front();
      served++;
    end
    r.occ = OccW'(keys.size());
    due_results.push_back(r);
  endfunction

  function void check_result(srq_result_t got);
    srq_result_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: valid=%0d id=%0d key=%0d status=%0d occ=%0d",
                 got.valid, got.id, got.key, got.status, got.occ);
      return;
    end
    want = due_results.pop_front();
    if (got.valid !== want.valid || got.id !== want.id || got.key !== want.key ||
        got.status !== want.status || got.occ !== want.occ) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: got valid=%0d id=%0d key=%0d status=%0d occ=%0d, ",
                  "want valid=%0d id=%0d key=%0d status=%0d occ=%0d"},
                 got.valid, got.id, got.key, got.status, got.occ,
                 want.valid, want.id, want.key, want.status, want.occ);
    end
  endfunction
endclass

module tb_sorted_ready_queue;
  import srq_pkg::*;

  localparam int unsigned CntW = $clog2(DepthDef + 1);

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i  = 1'b0;
  logic                   req_valid_i = 1'b0;
  logic                   req_stall_o;
  logic                   cmd_i       = 1'b0;
  logic [IdWidthDef-1:0]  in_id_i     = '0;
  logic [KeyWidthDef-1:0] in_key_i    = '0;
  logic                   res_valid_o;
  logic                   res_stall_i = 1'b0;
  logic                   out_valid_o;
  logic [IdWidthDef-1:0]  out_id_o;
  logic [KeyWidthDef-1:0] out_key_o;
  logic [1:0]             status_o;
  logic [CntW-1:0]        occupancy_o;

  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  ready_queue_tracker     sb;

  sorted_ready_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .cmd_i       (cmd_i),
    .in_id_i     (in_id_i),
    .in_key_i    (in_key_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_valid_o (out_valid_o),
    .out_id_o    (out_id_o),
    .out_key_o   (out_key_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    srq_result_t got;
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        got.valid  = out_valid_o;
        got.id     = out_id_o;
        got.key    = out_key_o;
        got.status = status_o;
        got.occ    = occupancy_o;
        sb.check_result(got);
      end
      res_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_request(cmd_e cmd, logic [IdWidthDef-1:0] id,
                              logic [KeyWidthDef-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    cmd_i       <= cmd;
    in_id_i     <= id;
    in_key_i    <= key;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_request(cmd, id, key);
  endtask

  task automatic wait_idle();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_mode(mode_e mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.mode = mode;
  endtask

  task automatic send_random(int push_pct);
    cmd_e                   cmd;
    logic [IdWidthDef-1:0]  id;
    logic [KeyWidthDef-1:0] key;
    cmd = ($urandom_range(0, 99) < push_pct) ? CmdPush : CmdPop;
    case ($urandom_range(0, 7))
      0:       id = '0;
      1:       id = '1;
      2:       id = IdWidthDef'($urandom_range(0, 7));
      default: id = IdWidthDef'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       key = '0;
      1:       key = '1;
      2, 3:    key = KeyWidthDef'($urandom_range(0, 7));
      default: key = KeyWidthDef'($urandom_range(0, 65535));
    endcase
    send_request(cmd, id, key);
  endtask

  task automatic run_random(int count);
    int push_pct;
    int burst;
    int left;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 90;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      burst = $urandom_range(20, 80);
      if (burst > left) burst = left;
      repeat (burst) send_random(push_pct);
      left -= burst;
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 22;
    recv_idle_pct = 52;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(ModeFifo);
    send_request(CmdPop, 8'd0, 16'd0);
    send_request(CmdPush, 8'd0, 16'h0000);
    send_request(CmdPush, 8'hFF, 16'hFFFF);
    send_request(CmdPush, 8'h5A, 16'hA5A5);
    send_request(CmdPush, 8'hA5, 16'h5A5A);
    repeat (4) send_request(CmdPop, 8'hFF, 16'hFFFF);
    send_request(CmdPop, 8'd0, 16'd0);
    wait_idle();

    write_mode(ModeSorted);
    send_request(CmdPush, 8'd10, 16'd100);
    send_request(CmdPush, 8'd5, 16'd100);
    send_request(CmdPush, 8'd7, 16'd50);
    send_request(CmdPush, 8'd200, 16'hFFFF);
    send_request(CmdPush, 8'd3, 16'd0);
    send_request(CmdPush, 8'd9, 16'd100);
    send_request(CmdPop, 8'd0, 16'd0);
    send_request(CmdPop, 8'd0, 16'd0);
    wait_idle();

    // switch modes with entries still queued
    write_mode(ModeFifo);
    send_request(CmdPush, 8'd1, 16'd0);
    wait_idle();
    write_mode(ModeSorted);
    send_request(CmdPush, 8'd4, 16'd50);
    send_request(CmdPop, 8'd0, 16'd0);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_mode(ModeFifo);
      run_random(108);
      wait_idle();
      write_mode(ModeSorted);
      run_random(108);
      wait_idle();
    end

    $display("Covered %0d requests in FIFO and sorted modes: %0d entries served,",
             sb.requests, sb.served);
    $display("  %0d pushes dropped on a full queue, %0d pops on an empty one",
             sb.drops, sb.empty_pops);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
